// ===== design/bsmv_pkg.sv =====
// ----------------------------------------------------------------------------
// bsmv_pkg: shared types and constants
// Request and result payloads, opcodes, register map and default sizes for
// the block-sparse fixed-point matrix-vector unit.
// ----------------------------------------------------------------------------
package bsmv_pkg;

  localparam int unsigned DefBlockHeight = 4;
  localparam int unsigned DefBlockWidth  = 4;
  localparam int unsigned DefVectorDepth = 1024;
  localparam int unsigned DefMaxReplicas = 4;

  localparam int unsigned ResultLimit = 16;
  localparam int unsigned AddrW       = 5;
  localparam int unsigned IndexW      = 20;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_BIAS   = 3'd1,
    OP_WEIGHT = 3'd2,
    OP_FINISH = 3'd3,
    OP_START  = 3'd4
  } bsmv_op_e;

  typedef enum logic [2:0] {
    REG_RELU   = 3'd0,
    REG_SHIFT  = 3'd1,
    REG_NARROW = 3'd2,
    REG_REPS   = 3'd3,
    REG_STRIDE = 3'd4
  } bsmv_reg_e;

  typedef struct packed {
    logic        [2:0]  opcode;
    logic        [1:0]  lane;
    logic        [7:0]  block_col;
    logic        [1:0]  col_offset;
    logic signed [15:0] small_value;
    logic signed [31:0] bias_value;
  } bsmv_in_t;

  typedef struct packed {
    logic signed [31:0]       result_value;
    logic        [IndexW-1:0] out_index;
    logic                     last;
  } bsmv_out_t;

  // snapshot handed from the execute stage to the result sequencer
  typedef struct packed {
    logic              start;
    logic [IndexW-1:0] base;
    logic [3:0]        reps;
    logic [15:0]       stride;
  } bsmv_emit_req_t;

endpackage

// ===== design/bsmv_emit.sv =====
// ----------------------------------------------------------------------------
// bsmv_emit: finish result sequencer
// Holds a snapshot of the processed row block; sends one result per cycle unless
// stalled, through an output register, lane by lane and replica by replica.
// ----------------------------------------------------------------------------
module bsmv_emit #(
  parameter int unsigned ROW_LANES = bsmv_pkg::DefBlockHeight
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bsmv_pkg::bsmv_emit_req_t req_i,
  input  logic [31:0]            vals_i [ROW_LANES],
  output logic                   busy_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output bsmv_pkg::bsmv_out_t    out_rsp_o
);
  import bsmv_pkg::*;

  localparam int unsigned LaneW = (ROW_LANES > 1) ? $clog2(ROW_LANES) : 1;

  logic              busy_q;
  logic [4:0]        left_q;
  logic [LaneW-1:0]  lane_q;
  logic [IndexW-1:0] roff_q, base_q;
  logic [15:0]       stride_q;
  logic [31:0]       vals_q [ROW_LANES];
  logic              out_valid_q;
  bsmv_out_t         out_q;

  logic              step;
  logic [7:0]        total;
  logic [31:0]       cur_val;

  assign step  = busy_q && (!out_valid_q || !out_stall_i);
  assign total = 8'(req_i.reps) * 8'(ROW_LANES);

  always_comb begin
    cur_val = '0;
    for (int i = 0; i < ROW_LANES; i++) begin
      if (lane_q == LaneW'(i)) cur_val = vals_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      left_q      <= '0;
      lane_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= step || (out_valid_q && out_stall_i);
      if (req_i.start && !busy_q) begin
        left_q <= (total > 8'(ResultLimit)) ? 5'(ResultLimit) : total[4:0];
        busy_q <= (total != 8'd0);
        lane_q <= '0;
      end else if (step) begin
        left_q      <= left_q - 5'd1;
        busy_q      <= (left_q != 5'd1);
        lane_q      <= (lane_q == LaneW'(ROW_LANES - 1)) ? '0 : lane_q + LaneW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      base_q   <= req_i.base;
      stride_q <= req_i.stride;
      roff_q   <= '0;
      vals_q   <= vals_i;
    end else if (step) begin
      out_q.result_value <= cur_val;
      out_q.out_index    <= base_q + IndexW'(lane_q) + roff_q;
      out_q.last         <= (left_q == 5'd1);
      if (lane_q == LaneW'(ROW_LANES - 1)) roff_q <= roff_q + IndexW'(stride_q);
    end
  end

  assign busy_o      = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// ===== design/block_sparse_matvec_fixed.sv =====
// ----------------------------------------------------------------------------
// block_sparse_matvec_fixed: block-sparse fixed-point matrix-vector multiply
// Vector store, row accumulators and per-row-block result sequencing.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  request | in  | in_valid_i/in_stall_o | in_req_i  (bsmv_in_t)
//  result  | out | out_valid_o/out_stall_i | out_rsp_o (bsmv_out_t)
//  config  | in  | APB psel/penable/pready | paddr, pwdata, prdata
//
//  One request per cycle while the input is not stalled: vector read on
//  acceptance, execute from the stage register. A finish request emits
//  min(min(reps,MAX_REPLICAS)*ROW_LANES,16) results, one per cycle from the
//  sequencer while the output is not stalled; a further finish waits until
//  the sequencer has issued that run's last result. A waiting finish stalls
//  the input, so output stall reaches the input only through it. Reset
//  clears accumulators and counter; the vector store holds no reset value.
// ----------------------------------------------------------------------------
module block_sparse_matvec_fixed #(
  parameter int unsigned ROW_LANES    = bsmv_pkg::DefBlockHeight,
  parameter int unsigned COL_SPAN     = bsmv_pkg::DefBlockWidth,
  parameter int unsigned VECTOR_DEPTH = bsmv_pkg::DefVectorDepth,
  parameter int unsigned MAX_REPLICAS = bsmv_pkg::DefMaxReplicas
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  bsmv_pkg::bsmv_in_t        in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output bsmv_pkg::bsmv_out_t       out_rsp_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bsmv_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import bsmv_pkg::*;

  localparam int unsigned AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
  localparam logic [20:0] Recip = 21'((1 << 24) / VECTOR_DEPTH);

  // configuration
  logic        relu_q, narrow_q;
  logic [4:0]  shift_q;
  logic [2:0]  reps_q;
  logic [15:0] stride_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relu_q   <= 1'b0;
      shift_q  <= '0;
      narrow_q <= 1'b0;
      reps_q   <= 3'd1;
      stride_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (bsmv_reg_e'(paddr[4:2]))
        REG_RELU:   relu_q   <= pwdata[0];
        REG_SHIFT:  shift_q  <= pwdata[4:0];
        REG_NARROW: narrow_q <= pwdata[0];
        REG_REPS:   reps_q   <= pwdata[2:0];
        REG_STRIDE: stride_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (bsmv_reg_e'(paddr[4:2]))
      REG_RELU:   prdata = {31'd0, relu_q};
      REG_SHIFT:  prdata = {27'd0, shift_q};
      REG_NARROW: prdata = {31'd0, narrow_q};
      REG_REPS:   prdata = {29'd0, reps_q};
      REG_STRIDE: prdata = {16'd0, stride_q};
      default:    prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // vector address: reduced modulo depth by reciprocal and one correction
  logic [11:0] lin_addr, quo, rem0;
  logic [32:0] quo_prod;
  logic [28:0] quo_back;
  logic [16:0] rem_ext;
  logic [AW-1:0] in_addr;

  always_comb begin
    lin_addr = 12'(in_req_i.block_col) * 12'(COL_SPAN) + 12'(in_req_i.col_offset);
    quo_prod = 33'(lin_addr) * 33'(Recip);
    quo      = 12'(quo_prod[32:24]);
    quo_back = 29'(quo) * 29'(VECTOR_DEPTH);
    rem0     = lin_addr - quo_back[11:0];
    rem_ext  = 17'(rem0);
    if (rem_ext >= 17'(VECTOR_DEPTH)) rem_ext = rem_ext - 17'(VECTOR_DEPTH);
    in_addr = rem_ext[AW-1:0];
  end

  // execute stage
  logic          s1_valid_q;
  bsmv_in_t      s1_q;
  logic [AW-1:0] s1_addr_q;
  logic [15:0]   rd_q, fwd_data_q;
  logic          fwd_q;
  logic [15:0]   mem_q [VECTOR_DEPTH];

  logic          accept, s1_adv, s1_load, emit_busy;
  logic [15:0]   vec_elem;
  logic [31:0]   prod;
  logic [31:0]   acc_q  [ROW_LANES];
  logic [31:0]   proc_v [ROW_LANES];
  logic [31:0]   snap_v [ROW_LANES];
  logic [15:0]   row_q;
  bsmv_emit_req_t emit_req;

  assign s1_adv     = s1_valid_q && !(s1_q.opcode == OP_FINISH && emit_busy);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;
  assign s1_load    = s1_adv && s1_q.opcode == OP_LOAD;

  assign vec_elem = fwd_q ? fwd_data_q : rd_q;
  assign prod     = 32'($signed(s1_q.small_value) * $signed(vec_elem));

  always_ff @(posedge clk_i) begin
    if (s1_load) mem_q[s1_addr_q] <= s1_q.small_value;
    if (accept) begin
      rd_q       <= mem_q[in_addr];
      fwd_q      <= s1_load && (s1_addr_q == in_addr);
      fwd_data_q <= s1_q.small_value;
      s1_q       <= in_req_i;
      s1_addr_q  <= in_addr;
    end
  end

  always_comb begin
    for (int i = 0; i < ROW_LANES; i++) begin
      proc_v[i] = (relu_q && acc_q[i][31]) ? 32'd0 : acc_q[i];
      proc_v[i] = 32'($signed(proc_v[i]) >>> shift_q);
      snap_v[i] = narrow_q ? {{16{proc_v[i][15]}}, proc_v[i][15:0]} : proc_v[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      row_q      <= '0;
      for (int i = 0; i < ROW_LANES; i++) acc_q[i] <= '0;
    end else begin
      if (accept)      s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;
      if (s1_adv) begin
        case (s1_q.opcode)
          OP_BIAS: begin
            for (int i = 0; i < ROW_LANES; i++)
              if (5'(s1_q.lane) == 5'(i)) acc_q[i] <= s1_q.bias_value;
          end
          OP_WEIGHT: begin
            for (int i = 0; i < ROW_LANES; i++)
              if (5'(s1_q.lane) == 5'(i)) acc_q[i] <= acc_q[i] + prod;
          end
          OP_FINISH: begin
            for (int i = 0; i < ROW_LANES; i++) acc_q[i] <= proc_v[i];
            row_q <= row_q + 16'd1;
          end
          OP_START: row_q <= '0;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    emit_req.start  = s1_adv && s1_q.opcode == OP_FINISH;
    emit_req.base   = IndexW'(IndexW'(row_q) * IndexW'(ROW_LANES));
    emit_req.reps   = (4'(reps_q) > 4'(MAX_REPLICAS)) ? 4'(MAX_REPLICAS) : 4'(reps_q);
    emit_req.stride = stride_q;
  end

  bsmv_emit #(
    .ROW_LANES(ROW_LANES)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (emit_req),
    .vals_i      (snap_v),
    .busy_o      (emit_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
